// File: src/clr_pkg.sv
// clr_pkg: shared constants for the clipped line and rectangle rasterizer
// command codes, clip status codes, register indexes and datapath widths
// no dependencies
package clr_pkg;

   localparam int REG_W   = 9;          // image_width / image_height registers
   localparam int PROD_W  = 2 * REG_W;  // row * width + column
   localparam int COORD_W = 14;         // coordinates incl. rectangle far corner
   localparam int DELTA_W = 15;         // bresenham deltas and error term
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [2:0] CMD_LINE  = 3'd0;
   localparam logic [2:0] CMD_HLINE = 3'd1;
   localparam logic [2:0] CMD_VLINE = 3'd2;
   localparam logic [2:0] CMD_RECT  = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [1:0] ST_INSIDE  = 2'd0;
   localparam logic [1:0] ST_PARTIAL = 2'd1;
   localparam logic [1:0] ST_OUTSIDE = 2'd2;

   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [REG_W-1:0] IMAGE_SIZE_RESET = 9'd256;

endpackage

// File: src/clipped_line_rect_rasterizer.sv
// clipped_line_rect_rasterizer: top level, command sequencer, pixel walker and csr
// depends on clr_pkg and clr_ram
//
// Draws lines, spans and filled rectangles into an 8-bit palette-index frame
// store (pixel x,y at address y*width+x) and reads single pixels back.
// Commands arrive on the req_ channel (valid/ready), one response per command
// leaves on the rsp_ channel (valid/ready) through an output register.
// Width and height are written over the apb port at 0x0 and 0x4; the user
// must do so only while idle, as the block does not enforce it. One command
// is worked on at a time. The walker emits one pixel per cycle into a
// one-stage address pipeline (row * width + column, registered) that writes
// the frame store. A line walks its bresenham steps (max(|dx|,|dy|)+1), a
// span or rectangle only its clipped pixels; off-image line steps are still
// walked but not written. A pixel read waits on the registered ram read
// port; a command with nothing to draw skips the walk.
// The next command is taken while the previous response still waits; a
// stalled receiver holds the block only once the following response is done.
// Reset sets width and height to 256 and empties the pipeline; frame store
// contents are undefined until drawn.
module clipped_line_rect_rasterizer
   import clr_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_cmd,
   input  logic [7:0]               req_colour,
   input  logic signed [11:0]       req_x0,
   input  logic signed [11:0]       req_y0,
   input  logic signed [11:0]       req_x1,
   input  logic signed [11:0]       req_y1,
   input  logic signed [11:0]       req_rect_w,
   input  logic signed [11:0]       req_rect_h,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_read_value,
   output logic [1:0]               rsp_clip_status,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_AW-1:0]        paddr,
   input  logic [CSR_DW-1:0]        pwdata,
   output logic [CSR_DW-1:0]        prdata,
   output logic                     pready
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SETUP = 8'b0000_0010,
      S_CLASS = 8'b0000_0100,
      S_LINE  = 8'b0000_1000,
      S_FILL  = 8'b0001_0000,
      S_READ  = 8'b0010_0000,
      S_RWAIT = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   // csr
   logic [REG_W-1:0] width_ff, height_ff;
   logic [REG_W-1:0] eff_w, eff_h;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_SIZE_RESET;
         height_ff <= IMAGE_SIZE_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == REG_IMAGE_WIDTH) begin
            width_ff <= pwdata[REG_W-1:0];
         end else begin
            height_ff <= pwdata[REG_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_IMAGE_WIDTH) ? CSR_DW'(width_ff) : CSR_DW'(height_ff);

   always_comb begin
      if (width_ff == '0) eff_w = REG_W'(1);
      else if (int'(width_ff) > MAX_WIDTH) eff_w = REG_W'(MAX_WIDTH);
      else eff_w = width_ff;
      if (height_ff == '0) eff_h = REG_W'(1);
      else if (int'(height_ff) > MAX_HEIGHT) eff_h = REG_W'(MAX_HEIGHT);
      else eff_h = height_ff;
   end

   // command state
   state_type                   state_ff, state_in;
   logic [2:0]                  cmd_ff, cmd_in;
   logic [7:0]                  colour_ff, colour_in;
   logic                        empty_ff, empty_in;
   logic signed [COORD_W-1:0]   ox_ff, ox_in, oy_ff, oy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic signed [COORD_W-1:0]   bxa_ff, bxa_in, bxb_ff, bxb_in, bya_ff, bya_in, byb_ff, byb_in;
   logic signed [COORD_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [COORD_W-1:0]   fxlo_ff, fxlo_in, fxhi_ff, fxhi_in, fyhi_ff, fyhi_in;
   logic signed [DELTA_W-1:0]   dx_ff, dx_in, dy_ff, dy_in, err_ff, err_in;
   logic                        sxp_ff, sxp_in, syp_ff, syp_in;
   logic [1:0]                  st_ff, st_in;
   logic                        rd_hit_ff, rd_hit_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_value_ff, rsp_value_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic                        we_ff, we_in, re_ff, re_in;

   logic signed [COORD_W-1:0]   ws, hs;
   logic [1:0]                  box_st;
   logic signed [DELTA_W:0]     e2;
   logic                        step_x, step_y, emit, in_image;
   logic [PROD_W-1:0]           lin;
   logic [7:0]                  ram_rdata;

   assign ws = $signed(COORD_W'(eff_w));
   assign hs = $signed(COORD_W'(eff_h));

   // bounding box against the image
   always_comb begin
      if (bxa_ff >= 0 && bxb_ff < ws && bya_ff >= 0 && byb_ff < hs) begin
         box_st = ST_INSIDE;
      end else if (bxb_ff < 0 || bxa_ff >= ws || byb_ff < 0 || bya_ff >= hs) begin
         box_st = ST_OUTSIDE;
      end else begin
         box_st = ST_PARTIAL;
      end
   end

   // bresenham step decision
   assign e2     = {err_ff, 1'b0};
   assign step_x = e2 >= (DELTA_W+1)'(dy_ff);
   assign step_y = e2 <= (DELTA_W+1)'(dx_ff);

   // pixel address, one multiply then a register
   assign emit     = (state_ff == S_LINE) || (state_ff == S_FILL);
   assign in_image = (x_ff >= 0) && (x_ff < ws) && (y_ff >= 0) && (y_ff < hs);
   assign lin      = PROD_W'(y_ff[REG_W-1:0]) * PROD_W'(eff_w) + PROD_W'(x_ff[REG_W-1:0]);
   assign addr_in  = AW'(lin);
   assign we_in    = emit & in_image;
   assign re_in    = (state_ff == S_READ);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      colour_in     = colour_ff;
      empty_in      = empty_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      bxa_in        = bxa_ff;
      bxb_in        = bxb_ff;
      bya_in        = bya_ff;
      byb_in        = byb_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      fxlo_in       = fxlo_ff;
      fxhi_in       = fxhi_ff;
      fyhi_in       = fyhi_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      err_in        = err_ff;
      sxp_in        = sxp_ff;
      syp_in        = syp_ff;
      st_in         = st_ff;
      rd_hit_in     = rd_hit_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               colour_in = req_colour;
               empty_in  = (req_rect_w <= 0) || (req_rect_h <= 0);
               ox_in     = COORD_W'(req_x0);
               oy_in     = COORD_W'(req_y0);
               case (req_cmd)
                  CMD_LINE: begin
                     ex_in = COORD_W'(req_x1);
                     ey_in = COORD_W'(req_y1);
                  end
                  CMD_HLINE: begin
                     ex_in = COORD_W'(req_x1);
                     ey_in = COORD_W'(req_y0);
                  end
                  CMD_VLINE: begin
                     ex_in = COORD_W'(req_x0);
                     ey_in = COORD_W'(req_y1);
                  end
                  CMD_RECT: begin
                     ex_in = COORD_W'(req_x0) + COORD_W'(req_rect_w) - COORD_W'(1);
                     ey_in = COORD_W'(req_y0) + COORD_W'(req_rect_h) - COORD_W'(1);
                  end
                  default: begin
                     ex_in = COORD_W'(req_x0);
                     ey_in = COORD_W'(req_y0);
                  end
               endcase
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            bxa_in = (ox_ff > ex_ff) ? ex_ff : ox_ff;
            bxb_in = (ox_ff > ex_ff) ? ox_ff : ex_ff;
            bya_in = (oy_ff > ey_ff) ? ey_ff : oy_ff;
            byb_in = (oy_ff > ey_ff) ? oy_ff : ey_ff;
            sxp_in = ox_ff < ex_ff;
            syp_in = oy_ff < ey_ff;
            dx_in  = (ex_ff > ox_ff) ? DELTA_W'(ex_ff) - DELTA_W'(ox_ff)
                                     : DELTA_W'(ox_ff) - DELTA_W'(ex_ff);
            dy_in  = (ey_ff > oy_ff) ? DELTA_W'(oy_ff) - DELTA_W'(ey_ff)
                                     : DELTA_W'(ey_ff) - DELTA_W'(oy_ff);
            x_in   = ox_ff;
            y_in   = oy_ff;
            state_in = S_CLASS;
         end
         S_CLASS: begin
            err_in    = dx_ff + dy_ff;
            rd_hit_in = 1'b0;
            // clipped fill range, used by spans and rectangles
            fxlo_in = (bxa_ff < 0) ? '0 : bxa_ff;
            fxhi_in = (bxb_ff >= ws) ? ws - COORD_W'(1) : bxb_ff;
            fyhi_in = (byb_ff >= hs) ? hs - COORD_W'(1) : byb_ff;
            st_in   = box_st;
            state_in = S_DONE;
            case (cmd_ff) inside
               CMD_LINE: begin
                  if (box_st != ST_OUTSIDE) state_in = S_LINE;
               end
               CMD_HLINE, CMD_VLINE, CMD_RECT: begin
                  if (cmd_ff == CMD_RECT && empty_ff) begin
                     st_in = ST_OUTSIDE;
                  end else if (box_st != ST_OUTSIDE) begin
                     x_in     = (bxa_ff < 0) ? '0 : bxa_ff;
                     y_in     = (bya_ff < 0) ? '0 : bya_ff;
                     state_in = S_FILL;
                  end
               end
               CMD_READ: begin
                  if (box_st == ST_INSIDE) begin
                     rd_hit_in = 1'b1;
                     state_in  = S_READ;
                  end
               end
               default: begin
                  st_in = ST_INSIDE;
               end
            endcase
         end
         S_LINE: begin
            if (x_ff == ex_ff && y_ff == ey_ff) begin
               state_in = S_DONE;
            end else begin
               err_in = err_ff + (step_x ? dy_ff : '0) + (step_y ? dx_ff : '0);
               if (step_x) x_in = sxp_ff ? x_ff + COORD_W'(1) : x_ff - COORD_W'(1);
               if (step_y) y_in = syp_ff ? y_ff + COORD_W'(1) : y_ff - COORD_W'(1);
            end
         end
         S_FILL: begin
            if (x_ff == fxhi_ff) begin
               if (y_ff == fyhi_ff) begin
                  state_in = S_DONE;
               end else begin
                  x_in = fxlo_ff;
                  y_in = y_ff + COORD_W'(1);
               end
            end else begin
               x_in = x_ff + COORD_W'(1);
            end
         end
         S_READ: begin
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // last write of this command lands in the ram before any later read
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_hit_ff ? ram_rdata : 8'd0;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         we_ff        <= 1'b0;
         re_ff        <= 1'b0;
         rd_hit_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         we_ff        <= we_in;
         re_ff        <= re_in;
         rd_hit_ff    <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      colour_ff     <= colour_in;
      empty_ff      <= empty_in;
      ox_ff         <= ox_in;
      oy_ff         <= oy_in;
      ex_ff         <= ex_in;
      ey_ff         <= ey_in;
      bxa_ff        <= bxa_in;
      bxb_ff        <= bxb_in;
      bya_ff        <= bya_in;
      byb_ff        <= byb_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      fxlo_ff       <= fxlo_in;
      fxhi_ff       <= fxhi_in;
      fyhi_ff       <= fyhi_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      err_ff        <= err_in;
      sxp_ff        <= sxp_in;
      syp_ff        <= syp_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      addr_ff       <= addr_in;
   end

   clr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (we_ff),
      .waddr (addr_ff),
      .wdata (colour_ff),
      .re    (re_ff),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_clip_status = rsp_status_ff;

endmodule

// File: src/clr_ram.sv
// clr_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
module clr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: src/clr_checker.sv
// clr_checker: port-level assertions for the rasterizer, bound to the top level
// depends on clr_pkg
module clr_checker
   import clr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_value,
   input logic [1:0] rsp_clip_status,
   input logic       pready
);

   // out of reset the block is empty and ready for a command
   a_reset_state: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("not idle after reset");

   // one command at a time: no new transfer right after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_clip_status == ST_INSIDE || rsp_clip_status == ST_PARTIAL
                     || rsp_clip_status == ST_OUTSIDE))
      else $error("bad clip status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_read_value) && $stable(rsp_clip_status)))
      else $error("stalled response changed");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind clipped_line_rect_rasterizer clr_checker u_clr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_value  (rsp_read_value),
   .rsp_clip_status (rsp_clip_status),
   .pready          (pready)
);
